/* hdl/pixel_kind_converter_packer_macros.svh */
// ---------------------------------------------------------------------------
// Pixel kind converter/packer assertion macros
// Short forms for the concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef PIXEL_KIND_CONVERTER_PACKER_MACROS_SVH
`define PIXEL_KIND_CONVERTER_PACKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pkc_pkg.sv */
// ---------------------------------------------------------------------------
// Pixel kind converter/packer package
// Kind codes, register indexes, reset values, shared types and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pkc_pkg;

  // pixel kind codes; code three is handled as rgb
  localparam logic [1:0] KIND_BILEVEL = 2'd0;
  localparam logic [1:0] KIND_GRAY    = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_KIND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_BITS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values
  localparam logic [1:0]  RST_INPUT_KIND  = KIND_GRAY;
  localparam logic [1:0]  RST_OUTPUT_KIND = KIND_GRAY;
  localparam logic [7:0]  RST_MAX_VALUE   = 8'd255;
  localparam logic        RST_PACK_BITS   = 1'b1;
  localparam logic [15:0] RST_ROW_WIDTH   = 16'd640;

  localparam logic [7:0] FULL_SAMPLE = 8'd255;
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0]  input_kind;
    logic [1:0]  output_kind;
    logic [7:0]  max_value;
    logic        pack_bits;
    logic [15:0] row_width;
  } cfg_t;

  // results of one pixel: up to three bytes, count, end-of-image flag
  typedef struct packed {
    logic [1:0]                         count;
    logic [MAX_RESULTS-1:0][7:0]        vals;
    logic                               last;
  } res_t;

  // floor(s/3) for s <= 765 via reciprocal 683/2048
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = {11'd0, s} * 21'd683;
    return p[18:11];
  endfunction

endpackage

`default_nettype wire

/* hdl/pkc_convert.sv */
// ---------------------------------------------------------------------------
// Pixel kind conversion and bilevel packing
// Turns one registered pixel into its result bytes; holds the packing state.
// ---------------------------------------------------------------------------
`default_nettype none

module pkc_convert (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pkc_pkg::cfg_t cfg,
  input  wire logic          fire,
  input  wire logic [7:0]    smp_r,
  input  wire logic [7:0]    smp_g,
  input  wire logic [7:0]    smp_b,
  input  wire logic          fin,
  output pkc_pkg::res_t      res
);

  logic [7:0]  bit_gather_r, bit_gather_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [15:0] column_count_r, column_count_nxt;

  logic        ik_bil, ik_rgb, ok_bil, ok_rgb;
  logic [9:0]  sum;
  logic [7:0]  mean, gray, thr, gather_new, fill;
  logic        black, row_end, emit;
  logic [16:0] col_inc;

  assign ik_bil = (cfg.input_kind == pkc_pkg::KIND_BILEVEL);
  assign ik_rgb = cfg.input_kind[1];
  assign ok_bil = (cfg.output_kind == pkc_pkg::KIND_BILEVEL);
  assign ok_rgb = cfg.output_kind[1];

  assign sum  = {2'b00, smp_r} + {2'b00, smp_g} + {2'b00, smp_b};
  assign mean = pkc_pkg::div3(sum);
  assign thr  = {1'b0, cfg.max_value[7:1]};

  always_comb begin
    if (ik_bil) begin
      black = smp_r[0];
      gray  = {7'd0, ~smp_r[0]};
    end else begin
      gray  = ik_rgb ? mean : smp_r;
      black = (gray <= thr);
    end
  end

  // packing: MSB first, emit on full byte, row end or final pixel
  assign gather_new = bit_gather_r | ({7'd0, black} << (3'd7 - bit_count_r));
  assign col_inc    = {1'b0, column_count_r} + 17'd1;
  // zero row width counts as 65536 pixels
  assign row_end    = (cfg.row_width == 16'd0) ? (column_count_r == 16'hFFFF)
                                               : (col_inc >= {1'b0, cfg.row_width});
  assign emit       = (bit_count_r == 3'd7) || row_end || fin;
  assign fill       = black ? 8'd0 : pkc_pkg::FULL_SAMPLE;

  always_comb begin
    res.last = fin;
    res.vals = '0;
    if (ok_rgb) begin
      res.count = 2'd3;
      if (ik_rgb) begin
        res.vals[0] = smp_r;
        res.vals[1] = smp_g;
        res.vals[2] = smp_b;
      end else if (ik_bil) begin
        res.vals = {fill, fill, fill};
      end else begin
        res.vals = {gray, gray, gray};
      end
    end else if (!ok_bil) begin
      res.count   = 2'd1;
      res.vals[0] = gray;
    end else if (!cfg.pack_bits) begin
      res.count   = 2'd1;
      res.vals[0] = {7'd0, black};
    end else begin
      res.count   = emit ? 2'd1 : 2'd0;
      res.vals[0] = gather_new;
    end
  end

  always_comb begin
    bit_gather_nxt   = bit_gather_r;
    bit_count_nxt    = bit_count_r;
    column_count_nxt = column_count_r;
    if (ok_bil && cfg.pack_bits) begin
      if (emit) begin
        bit_gather_nxt = '0;
        bit_count_nxt  = '0;
      end else begin
        bit_gather_nxt = gather_new;
        bit_count_nxt  = bit_count_r + 3'd1;
      end
      column_count_nxt = (row_end || fin) ? 16'd0 : col_inc[15:0];
    end
    if (fin) begin
      bit_gather_nxt   = '0;
      bit_count_nxt    = '0;
      column_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_gather_r   <= '0;
      bit_count_r    <= '0;
      column_count_r <= '0;
    end else if (fire) begin
      bit_gather_r   <= bit_gather_nxt;
      bit_count_r    <= bit_count_nxt;
      column_count_r <= column_count_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/pkc_out_buffer.sv */
// ---------------------------------------------------------------------------
// Result buffer
// Holds one pixel's bytes, handed out one word per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module pkc_out_buffer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire pkc_pkg::res_t res,
  output logic               load_ready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);

  logic [1:0]                        cnt_r, cnt_nxt;
  logic [pkc_pkg::MAX_RESULTS-1:0][7:0] vals_r, vals_nxt;
  logic                              last_r, last_nxt;
  logic                              pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = vals_r[0];
  assign out_tlast  = last_r && (cnt_r == 2'd1);
  assign pop        = out_tvalid && out_tready;
  assign load_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_comb begin
    cnt_nxt  = cnt_r;
    vals_nxt = vals_r;
    last_nxt = last_r;
    if (load) begin
      cnt_nxt  = res.count;
      vals_nxt = res.vals;
      last_nxt = res.last;
    end else if (pop) begin
      cnt_nxt  = cnt_r - 2'd1;
      vals_nxt = {8'd0, vals_r[2], vals_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vals_r <= vals_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

/* hdl/pixel_kind_converter_packer.sv */
// ---------------------------------------------------------------------------
// Pixel kind converter and bilevel packer
// Converts a pixel stream between bilevel, gray and rgb, packs bilevel bytes.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per word. tdata holds red/gray/bit in bits 7:0, green in
//           15:8, blue in 23:16; tlast marks the final pixel of the image.
//   out_* : one byte per word (gray sample, rgb channel in r,g,b order,
//           bilevel bit or packed byte); tlast on the image's last word.
//   cfg_* : register writes (index 0..4), always accepted; write only while
//           the stream is idle.
// Path: a taken pixel passes the input register, then the result buffer,
//   before its first result word is valid.
// Throughput: one pixel per cycle for gray and bilevel output while out_tready
//   is high; rgb output gives three words per pixel, so the single-byte output
//   port draining the result buffer paces it. Packed bilevel gives a word only
//   per byte, row end or final pixel.
// Reset: registers go to gray->gray, max 255, packing on, 640-pixel rows;
//   packing state and both stages are emptied.
// Stall: when out_tready is low the result buffer holds its word; one more
//   pixel waits in the input register, then in_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_kind_converter_packer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input pixels
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,  // sample_first, sample_second, sample_third
  input  wire logic                            in_tlast,  // final_pixel
  // result words
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [7:0]                           out_tdata, // out_value
  output logic                                 out_tlast, // end_of_image
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pkc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pkc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pkc_pkg::cfg_t cfg_r;
  pkc_pkg::res_t res;

  logic        in_vld_r;
  logic [7:0]  smp_r_r, smp_g_r, smp_b_r;
  logic        fin_r;
  logic        buf_ready, fire, in_take;

  // ---- configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_kind  <= pkc_pkg::RST_INPUT_KIND;
      cfg_r.output_kind <= pkc_pkg::RST_OUTPUT_KIND;
      cfg_r.max_value   <= pkc_pkg::RST_MAX_VALUE;
      cfg_r.pack_bits   <= pkc_pkg::RST_PACK_BITS;
      cfg_r.row_width   <= pkc_pkg::RST_ROW_WIDTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        pkc_pkg::REG_INPUT_KIND:  cfg_r.input_kind  <= cfg_data[1:0];
        pkc_pkg::REG_OUTPUT_KIND: cfg_r.output_kind <= cfg_data[1:0];
        pkc_pkg::REG_MAX_VALUE:   cfg_r.max_value   <= cfg_data[7:0];
        pkc_pkg::REG_PACK_BITS:   cfg_r.pack_bits   <= cfg_data[0];
        pkc_pkg::REG_ROW_WIDTH:   cfg_r.row_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- input register: pixel moves on when the buffer can load it
  assign fire      = in_vld_r && buf_ready;
  assign in_tready = !in_vld_r || buf_ready;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r_r <= in_tdata[7:0];
      smp_g_r <= in_tdata[15:8];
      smp_b_r <= in_tdata[23:16];
      fin_r   <= in_tlast;
    end
  end

  // ---- conversion and packing state
  pkc_convert u_convert (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .smp_r (smp_r_r),
    .smp_g (smp_g_r),
    .smp_b (smp_b_r),
    .fin   (fin_r),
    .res   (res)
  );

  // ---- result buffer, one byte per output word
  pkc_out_buffer u_out_buffer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .load_ready (buf_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* hdl/pkc_checker.sv */
// ---------------------------------------------------------------------------
// Pixel kind converter/packer port checker
// Watches the top-level ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pixel_kind_converter_packer_macros.svh"

module pkc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [23:0]                     in_tdata,
  input wire logic                            in_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [7:0]                      out_tdata,
  input wire logic                            out_tlast,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [pkc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [pkc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic in_seen, cfg_seen;

  // keep every port read
  assign in_seen  = in_tvalid && in_tlast && (in_tdata != '0);
  assign cfg_seen = cfg_valid && (cfg_index != '0) && (cfg_data != '0);

  // stalled result word holds
  `PKC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output word changed")
  // nothing comes out right after reset, and the input is ready
  `PKC_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_tvalid && in_tready, "output not empty after reset")
  // an empty output side never blocks the input
  `PKC_ASSERT_NOW(a_in_free, !out_tvalid, in_tready || in_seen, "input stalled with empty output")
  // register port never pushes back
  `PKC_ASSERT_NOW(a_cfg_ready, cfg_valid || cfg_seen, cfg_ready, "register write refused")

endmodule

bind pixel_kind_converter_packer pkc_checker u_pkc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);

`default_nettype wire
